// ===== rtl/msbs_pkg.sv =====
// ----------------------------------------------------------------------------
// msbs_pkg
// Shared types, register table and byte decode functions for the register
// space bus slave.
// ----------------------------------------------------------------------------
package msbs_pkg;

    localparam int SPACE_BYTES = 1024;
    localparam int ADDR_W      = $clog2(SPACE_BYTES);
    // one extra bit so that offset plus byte index can run past the space
    localparam int IDX_W       = ADDR_W + 1;

    // request kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // access size codes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    // special registers
    localparam logic [ADDR_W-1:0] TRR1_BASE   = ADDR_W'(10'h144);
    localparam logic [ADDR_W-1:0] TRR2_BASE   = ADDR_W'(10'h184);
    localparam logic [15:0]       TRR_RESET   = 16'hffff;
    localparam logic [ADDR_W-1:0] UIPCR_BASE  = ADDR_W'(10'h1d0);
    localparam logic [7:0]        UIPCR_RESET = 8'h0e;
    localparam logic [ADDR_W-1:0] PADAT_BASE  = ADDR_W'(10'h248);
    localparam logic [15:0]       PADAT_STRAP = 16'h0200;
    localparam logic [7:0]        FULL_MASK   = 8'hff;

    localparam int ROW_COUNT = 36;

    localparam logic [ADDR_W-1:0] ROW_BASE [ROW_COUNT] = '{
        10'h080, 10'h084, 10'h08a, 10'h08c, 10'h090, 10'h096, 10'h098, 10'h09c,
        10'h0a2, 10'h0a4, 10'h0a8, 10'h0ae, 10'h0b0, 10'h0b4, 10'h0ba, 10'h0bc,
        10'h0c0, 10'h0c6, 10'h100, 10'h108, 10'h10c, 10'h110, 10'h114, 10'h140,
        10'h144, 10'h148, 10'h14c, 10'h151, 10'h180, 10'h184, 10'h188, 10'h18c,
        10'h191, 10'h1d0, 10'h244, 10'h248
    };

    localparam logic [2:0] ROW_WIDTH [ROW_COUNT] = '{
        3'd2, 3'd4, 3'd2, 3'd2, 3'd4, 3'd2, 3'd2, 3'd4,
        3'd2, 3'd2, 3'd4, 3'd2, 3'd2, 3'd4, 3'd2, 3'd2,
        3'd4, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd1, 3'd1, 3'd2, 3'd2
    };

    localparam logic ROW_RO [ROW_COUNT] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b0, 1'b0
    };

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MERGE,
        ST_FINISH
    } t_state;

    // write port request into the byte store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_req;

    function automatic logic row_hit(input logic [ADDR_W-1:0] addr, input int i);
        logic [ADDR_W-1:0] rel;
        rel = addr - ROW_BASE[i];
        return (addr >= ROW_BASE[i]) && (rel < ADDR_W'(ROW_WIDTH[i]));
    endfunction

    function automatic logic is_listed(input logic [ADDR_W-1:0] addr);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < ROW_COUNT; i++) begin
            hit = hit | row_hit(addr, i);
        end
        return hit;
    endfunction

    function automatic logic is_byte_only(input logic [ADDR_W-1:0] addr);
        return addr == UIPCR_BASE;
    endfunction

    // bits set keep their stored value on a write
    function automatic logic [7:0] prot_mask(input logic [ADDR_W-1:0] addr);
        logic [7:0] m;
        m = FULL_MASK;
        for (int i = 0; i < ROW_COUNT; i++) begin
            if (row_hit(addr, i)) begin
                m = ROW_RO[i] ? FULL_MASK : 8'h00;
            end
        end
        if (addr == PADAT_BASE) begin
            m = m | PADAT_STRAP[15:8];
        end
        if (addr == PADAT_BASE + ADDR_W'(1)) begin
            m = m | PADAT_STRAP[7:0];
        end
        return m;
    endfunction

    function automatic logic [7:0] reset_byte(input logic [ADDR_W-1:0] addr);
        logic [7:0] v;
        v = 8'h00;
        if (addr == TRR1_BASE || addr == TRR2_BASE) begin
            v = TRR_RESET[15:8];
        end
        if (addr == TRR1_BASE + ADDR_W'(1) || addr == TRR2_BASE + ADDR_W'(1)) begin
            v = TRR_RESET[7:0];
        end
        if (addr == UIPCR_BASE) begin
            v = UIPCR_RESET;
        end
        return v;
    endfunction

endpackage

// ===== rtl/msbs_store.sv =====
// ----------------------------------------------------------------------------
// msbs_store
// Byte store of the register space: one write and one registered read port,
// with a sweep after reset that loads the table reset values.
// ----------------------------------------------------------------------------
module msbs_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [msbs_pkg::ADDR_W-1:0]   i_rd_addr,
    output logic [7:0]                    o_rd_data,
    input  msbs_pkg::t_wr_req             i_wr,
    output logic                          o_ready
);

    logic [7:0]                  mem [msbs_pkg::SPACE_BYTES];
    logic                        r_clr_busy;
    logic [msbs_pkg::ADDR_W-1:0] r_clr_addr;
    logic                        we;
    logic [msbs_pkg::ADDR_W-1:0] waddr;
    logic [7:0]                  wdata;
    logic [7:0]                  r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + msbs_pkg::ADDR_W'(1);
            if (r_clr_addr == msbs_pkg::ADDR_W'(msbs_pkg::SPACE_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = msbs_pkg::reset_byte(r_clr_addr);
        end else begin
            we    = i_wr.en;
            waddr = i_wr.addr;
            wdata = i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_clr_busy;

endmodule

// ===== rtl/masked_register_space_bus_slave.sv =====
// ----------------------------------------------------------------------------
// masked_register_space_bus_slave
// Big-endian byte-addressed register space slave with per-byte write masks.
// ----------------------------------------------------------------------------
// Flow: an access of n bytes (1, 2 or 4) takes each byte through a read and a
//   merge state, then a finish state loads the output register; a refused access
//   goes from idle straight to the finish state. One access at a time: tready
//   stays low until the finish state has handed the result to the output register.
// Reset: a sweep over all 1024 bytes loads the reset values; tready stays low meanwhile.
// ----------------------------------------------------------------------------
module masked_register_space_bus_slave (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // offset[9:0], access_size[11:10], write_data[43:12]
    input  logic        i_s_tuser,  // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // read_data[31:0]
    output logic [1:0]  o_m_tuser   // status[0], unmodelled[1]
);

    localparam int AW = msbs_pkg::ADDR_W;
    localparam int IW = msbs_pkg::IDX_W;

    msbs_pkg::t_state r_state, n_state;
    logic             r_is_wr, n_is_wr;
    logic [AW-1:0]    r_addr, n_addr;
    logic [1:0]       r_k, n_k;
    logic [1:0]       r_last_k, n_last_k;
    logic [31:0]      r_wdata, n_wdata;
    logic [31:0]      r_value, n_value;
    logic             r_status, n_status;
    logic             r_unmod, n_unmod;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_data, n_out_data;
    logic [1:0]       r_out_user, n_out_user;

    logic             s_accept;
    logic [AW-1:0]    in_offset;
    logic [1:0]       in_size;
    logic [31:0]      in_wdata;
    logic [IW-1:0]    idx;
    logic             beyond;
    logic [7:0]       rd_data;
    logic [7:0]       pm;
    logic             store_ready;
    msbs_pkg::t_wr_req wr_req;

    assign in_offset = i_s_tdata[AW-1:0];
    assign in_size   = i_s_tdata[11:10];
    assign in_wdata  = i_s_tdata[43:12];

    assign idx    = {1'b0, r_addr} + IW'(r_k);
    assign beyond = idx >= IW'(msbs_pkg::SPACE_BYTES);
    assign pm     = msbs_pkg::prot_mask(idx[AW-1:0]);

    msbs_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (idx[AW-1:0]),
        .o_rd_data (rd_data),
        .i_wr      (wr_req),
        .o_ready   (store_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msbs_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_is_wr    <= n_is_wr;
        r_addr     <= n_addr;
        r_k        <= n_k;
        r_last_k   <= n_last_k;
        r_wdata    <= n_wdata;
        r_value    <= n_value;
        r_status   <= n_status;
        r_unmod    <= n_unmod;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign s_accept = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state     = r_state;
        n_is_wr     = r_is_wr;
        n_addr      = r_addr;
        n_k         = r_k;
        n_last_k    = r_last_k;
        n_wdata     = r_wdata;
        n_value     = r_value;
        n_status    = r_status;
        n_unmod     = r_unmod;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_valid = r_out_valid && !i_m_tready;
        o_s_tready  = 1'b0;
        wr_req      = '0;

        unique case (r_state)
            msbs_pkg::ST_CLEAR: begin
                if (store_ready) begin
                    n_state = msbs_pkg::ST_IDLE;
                end
            end
            msbs_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (s_accept) begin
                    n_is_wr  = i_s_tuser == msbs_pkg::REQ_WRITE;
                    n_addr   = in_offset;
                    n_k      = 2'd0;
                    n_value  = '0;
                    n_status = 1'b0;
                    n_unmod  = 1'b0;
                    n_state  = msbs_pkg::ST_READ;
                    // write data is left-justified so each byte leaves from the top
                    case (in_size)
                        msbs_pkg::SIZE_BYTE: begin
                            n_last_k = 2'd0;
                            n_wdata  = {in_wdata[7:0], 24'h0};
                        end
                        msbs_pkg::SIZE_HALF: begin
                            n_last_k = 2'd1;
                            n_wdata  = {in_wdata[15:0], 16'h0};
                        end
                        default: begin
                            n_last_k = 2'd3;
                            n_wdata  = in_wdata;
                        end
                    endcase
                    if (in_size == msbs_pkg::SIZE_BAD) begin
                        n_status = 1'b1;
                        n_state  = msbs_pkg::ST_FINISH;
                    end else if (!msbs_pkg::is_listed(in_offset)) begin
                        n_unmod = 1'b1;
                    end else if (msbs_pkg::is_byte_only(in_offset)
                                 && in_size != msbs_pkg::SIZE_BYTE) begin
                        n_status = 1'b1;
                        n_state  = msbs_pkg::ST_FINISH;
                    end
                end
            end
            msbs_pkg::ST_READ: begin
                n_state = msbs_pkg::ST_MERGE;
            end
            msbs_pkg::ST_MERGE: begin
                if (r_is_wr) begin
                    wr_req.en   = !beyond;
                    wr_req.addr = idx[AW-1:0];
                    wr_req.data = (rd_data & pm) | (r_wdata[31:24] & ~pm);
                    n_wdata     = {r_wdata[23:0], 8'h0};
                end else begin
                    n_value = {r_value[23:0], beyond ? 8'h00 : rd_data};
                end
                if (r_k == r_last_k) begin
                    n_state = msbs_pkg::ST_FINISH;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = msbs_pkg::ST_READ;
                end
            end
            msbs_pkg::ST_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    // value never shifts on writes or refusals, so it is zero there
                    n_out_data  = r_value;
                    n_out_user  = {r_unmod, r_status};
                    n_out_valid = 1'b1;
                    n_state     = msbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = msbs_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

// ===== rtl/msbs_checker.sv =====
// ----------------------------------------------------------------------------
// msbs_checker
// Port-level checks for the register space bus slave, bound to the top level.
// ----------------------------------------------------------------------------
module msbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // one access at a time: never ready right after an input transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted on back-to-back cycles");

    // refused accesses return zero data
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == 32'h0)
        else $error("refused access returned nonzero data");

    // a refusal is never flagged as unlisted
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("status and unmodelled both set");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

endmodule

bind masked_register_space_bus_slave msbs_checker u_msbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
